// File: sv/axis_homing_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Axis homing sequencer assertion macros
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef AXIS_HOMING_SEQUENCER_DEFINES_SVH
`define AXIS_HOMING_SEQUENCER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked assertion that is switched off while reset is high.
`define AXHS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that is checked during reset as well.
`define AXHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AXHS_ASSERT(lbl, clk, rst, prop, msg)
`define AXHS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/axhs_pkg.sv
// ----------------------------------------------------------------------------
// Axis homing sequencer package
// Shared types, codes, constants and the homing method decode.
// ----------------------------------------------------------------------------
package axhs_pkg;

   localparam int unsigned ADDR_W      = 5;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned POS_W       = 48;
   localparam int unsigned MAG_W       = 31;
   localparam int unsigned PCT_W       = 8;
   localparam int unsigned PROD_W      = MAG_W + PCT_W;
   localparam int unsigned QUOT_W      = 33;
   localparam int unsigned RECIP_W     = 38;
   localparam int unsigned RECIP_SPLIT = 19;
   localparam int unsigned RECIP_SHIFT = 42;

   // ceil(2^42 / 25): exact floor division by 25 for numerators below 2^37.
   localparam logic [RECIP_W-1:0] RECIP_25 = 38'd175921860445;

   localparam logic [PCT_W-1:0] PCT_UNITY       = 8'd100;
   localparam logic [3:0]       MODE_DIRECT     = 4'd0;
   localparam logic [3:0]       MODE_DIRECT_ALT = 4'd15;
   localparam logic             ACTION_START    = 1'b0;

   typedef enum logic [2:0] {
      STEP_INIT     = 3'd0,
      STEP_SEARCH   = 3'd1,
      STEP_RETURN   = 3'd2,
      STEP_APPROACH = 3'd3,
      STEP_INDEX    = 3'd4,
      STEP_IDLE     = 3'd5
   } step_type;

   typedef enum logic [1:0] {
      KIND_SEARCH   = 2'd0,
      KIND_RETURN   = 2'd1,
      KIND_APPROACH = 2'd2,
      KIND_INDEX    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_SPEED = 2'd1,
      ERR_ACCEL = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      REG_HOMING_MODE  = 3'd0,
      REG_SWITCH_BIT   = 3'd1,
      REG_INDEX_BIT    = 3'd2,
      REG_SEARCH_SPEED = 3'd3,
      REG_RETURN_SPEED = 3'd4,
      REG_ACCEL_LIMIT  = 3'd5,
      REG_JERK_LIMIT   = 3'd6
   } reg_type;

   typedef struct packed {
      logic [3:0]       homing_mode;
      logic [2:0]       switch_bit;
      logic [2:0]       index_bit;
      logic [MAG_W-1:0] search_speed;
      logic [MAG_W-1:0] return_speed;
      logic [MAG_W-1:0] accel_limit;
      logic [MAG_W-1:0] jerk_limit;
   } cfg_type;

   typedef struct packed {
      logic                    action;
      logic signed [POS_W-1:0] home_position;
      logic [7:0]              switch_byte;
      logic [7:0]              index_byte;
      logic signed [POS_W-1:0] actual_position;
      logic signed [POS_W-1:0] planner_position;
      logic                    planner_done;
      logic [PCT_W-1:0]        override_percent;
   } item_type;

   typedef struct packed {
      logic pol;
      logic sneg;
      logic rneg;
      logic soi;
      logic aft;
   } method_type;

   typedef struct packed {
      logic                  issue;
      kind_type              kind;
      logic                  neg;
      logic                  hold;
      logic                  done;
      err_type               err;
      logic signed [POS_W:0] diff;
   } dec_type;

   typedef struct packed {
      logic adv;
      logic load;
   } seq_ctrl_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   function automatic method_type axhs_decode(input logic [3:0] m);
      method_type r;
      r.pol  = m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13, 4'd14};
      r.sneg = m inside {4'd1, 4'd2, 4'd5, 4'd6, 4'd9, 4'd10, 4'd13};
      r.rneg = m inside {4'd3, 4'd4, 4'd7, 4'd8, 4'd9, 4'd10, 4'd14};
      r.soi  = !(m inside {4'd5, 4'd6, 4'd7, 4'd8});
      r.aft  = !(m inside {4'd9, 4'd10, 4'd11, 4'd12});
      return r;
   endfunction

endpackage

// File: sv/axhs_csr.sv
// ----------------------------------------------------------------------------
// Axis homing sequencer register file
// APB-style write and read access to the seven configuration registers.
// ----------------------------------------------------------------------------
module axhs_csr
   import axhs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_type sel;

   assign sel = reg_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (sel)
            REG_HOMING_MODE:  cfg_in.homing_mode  = pwdata[3:0];
            REG_SWITCH_BIT:   cfg_in.switch_bit   = pwdata[2:0];
            REG_INDEX_BIT:    cfg_in.index_bit    = pwdata[2:0];
            REG_SEARCH_SPEED: cfg_in.search_speed = pwdata[MAG_W-1:0];
            REG_RETURN_SPEED: cfg_in.return_speed = pwdata[MAG_W-1:0];
            REG_ACCEL_LIMIT:  cfg_in.accel_limit  = pwdata[MAG_W-1:0];
            REG_JERK_LIMIT:   cfg_in.jerk_limit   = pwdata[MAG_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_HOMING_MODE:  prdata = DATA_W'(cfg_ff.homing_mode);
         REG_SWITCH_BIT:   prdata = DATA_W'(cfg_ff.switch_bit);
         REG_INDEX_BIT:    prdata = DATA_W'(cfg_ff.index_bit);
         REG_SEARCH_SPEED: prdata = DATA_W'(cfg_ff.search_speed);
         REG_RETURN_SPEED: prdata = DATA_W'(cfg_ff.return_speed);
         REG_ACCEL_LIMIT:  prdata = DATA_W'(cfg_ff.accel_limit);
         REG_JERK_LIMIT:   prdata = DATA_W'(cfg_ff.jerk_limit);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/axhs_scale.sv
// ----------------------------------------------------------------------------
// Axis homing sequencer override scaler
// Three-stage floor(magnitude * percent / 100) using a split reciprocal.
// ----------------------------------------------------------------------------
module axhs_scale
   import axhs_pkg::*;
(
   input  logic              clock,
   input  stage_en_type      en,
   input  logic [MAG_W-1:0]  mag,
   input  logic [PCT_W-1:0]  pct,
   output logic [QUOT_W-1:0] quot
);

   localparam int unsigned Y_W   = PROD_W - 2;
   localparam int unsigned LO_W  = RECIP_SPLIT;
   localparam int unsigned PP_W  = Y_W + LO_W;
   localparam int unsigned SUM_W = Y_W + RECIP_W;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PP_W-1:0]   hi_ff;
   logic [PP_W-1:0]   hi_in;
   logic [PP_W-1:0]   lo_ff;
   logic [PP_W-1:0]   lo_in;
   logic [QUOT_W-1:0] quot_ff;
   logic [QUOT_W-1:0] quot_in;
   logic [Y_W-1:0]    y;
   logic [SUM_W-1:0]  sum;

   // Dividing by 100 is a shift by two followed by an exact divide by 25.
   assign prod_in = PROD_W'(mag) * PROD_W'(pct);
   assign y       = prod_ff[PROD_W-1:2];
   assign hi_in   = PP_W'(y) * PP_W'(RECIP_25[RECIP_W-1:LO_W]);
   assign lo_in   = PP_W'(y) * PP_W'(RECIP_25[LO_W-1:0]);
   assign sum     = {hi_ff, {LO_W{1'b0}}} + SUM_W'(lo_ff);
   assign quot_in = sum[RECIP_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
      end
      if (en.s2) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (en.s3) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// File: sv/axhs_seq.sv
// ----------------------------------------------------------------------------
// Axis homing sequencer step logic
// Homing state machine, position capture and plan decision for each item.
// ----------------------------------------------------------------------------
`include "axis_homing_sequencer_defines.svh"

module axhs_seq
   import axhs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seq_ctrl_type ctrl,
   input  cfg_type      cfg,
   input  item_type     item,
   output dec_type      dec
);

   step_type                step_ff;
   step_type                step_in;
   logic signed [POS_W-1:0] target_ff;
   logic signed [POS_W-1:0] target_in;
   logic signed [POS_W-1:0] captured_ff;
   logic signed [POS_W-1:0] captured_in;
   logic [PCT_W-1:0]        last_ff;
   logic [PCT_W-1:0]        last_in;
   logic                    snap_ff;
   logic                    snap_in;
   dec_type                 dec_ff;
   dec_type                 dec_in;

   method_type              mth;
   logic                    sw;
   logic                    idx;
   logic                    chg;
   logic                    plan;
   kind_type                plan_kind;
   logic                    plan_neg;
   logic                    fin;
   logic signed [POS_W-1:0] cap_sel;

   always_comb begin
      mth = axhs_decode(cfg.homing_mode);
      sw  = (item.switch_byte[cfg.switch_bit] == mth.pol);
      idx = item.index_byte[cfg.index_bit];
      chg = !snap_ff || (item.override_percent != last_ff);

      step_in     = step_ff;
      target_in   = target_ff;
      captured_in = captured_ff;
      last_in     = last_ff;
      snap_in     = snap_ff;
      dec_in      = '0;
      plan        = 1'b0;
      plan_kind   = KIND_SEARCH;
      plan_neg    = 1'b0;
      fin         = 1'b0;
      cap_sel     = captured_ff;

      if (item.action == ACTION_START) begin
         target_in   = item.home_position;
         captured_in = '0;
         step_in     = STEP_INIT;
         last_in     = PCT_UNITY;
         snap_in     = 1'b0;
      end else begin
         unique case (step_ff)
            STEP_INIT: begin
               if (cfg.homing_mode == MODE_DIRECT || cfg.homing_mode == MODE_DIRECT_ALT) begin
                  cap_sel     = item.actual_position;
                  captured_in = item.actual_position;
                  fin         = 1'b1;
               end else if (cfg.search_speed == '0 || cfg.return_speed == '0) begin
                  dec_in.err = ERR_SPEED;
                  step_in    = STEP_IDLE;
               end else if (cfg.accel_limit == '0) begin
                  dec_in.err = ERR_ACCEL;
                  step_in    = STEP_IDLE;
               end else begin
                  plan      = 1'b1;
                  plan_kind = KIND_SEARCH;
                  plan_neg  = mth.sneg;
                  step_in   = STEP_SEARCH;
               end
            end
            STEP_SEARCH: begin
               if (sw) begin
                  plan     = 1'b1;
                  plan_neg = mth.rneg;
                  if (mth.soi && !mth.aft) begin
                     plan_kind = KIND_INDEX;
                     step_in   = STEP_INDEX;
                  end else begin
                     plan_kind = KIND_RETURN;
                     step_in   = STEP_RETURN;
                  end
               end else if (chg) begin
                  plan      = 1'b1;
                  plan_kind = KIND_SEARCH;
                  plan_neg  = mth.sneg;
               end
            end
            STEP_RETURN: begin
               if (!sw) begin
                  plan     = 1'b1;
                  plan_neg = mth.rneg;
                  if (mth.soi) begin
                     plan_kind = KIND_INDEX;
                     step_in   = STEP_INDEX;
                  end else begin
                     captured_in = item.actual_position;
                     plan_kind   = KIND_APPROACH;
                     step_in     = STEP_APPROACH;
                  end
               end else if (chg) begin
                  plan      = 1'b1;
                  plan_kind = KIND_RETURN;
                  plan_neg  = mth.rneg;
               end
            end
            STEP_APPROACH: begin
               if (chg) begin
                  plan      = 1'b1;
                  plan_kind = KIND_APPROACH;
                  plan_neg  = mth.rneg;
               end
               if (item.planner_done) begin
                  fin = 1'b1;
               end
            end
            STEP_INDEX: begin
               if (idx) begin
                  cap_sel     = item.planner_position;
                  captured_in = item.planner_position;
                  dec_in.hold = 1'b1;
                  fin         = 1'b1;
               end else if (item.planner_done || chg) begin
                  plan      = 1'b1;
                  plan_kind = KIND_INDEX;
                  plan_neg  = mth.rneg;
               end
            end
            STEP_IDLE: begin
               step_in = STEP_IDLE;
            end
            default: begin
               step_in = STEP_IDLE;
            end
         endcase

         if (plan) begin
            dec_in.issue = 1'b1;
            dec_in.kind  = plan_kind;
            dec_in.neg   = plan_neg;
            last_in      = item.override_percent;
            snap_in      = 1'b1;
         end
         if (fin) begin
            step_in     = STEP_IDLE;
            dec_in.done = 1'b1;
            dec_in.diff = (POS_W + 1)'(target_ff) - (POS_W + 1)'(cap_sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_INIT;
         target_ff   <= '0;
         captured_ff <= '0;
         last_ff     <= PCT_UNITY;
         snap_ff     <= 1'b0;
      end else if (ctrl.load) begin
         step_ff     <= step_in;
         target_ff   <= target_in;
         captured_ff <= captured_in;
         last_ff     <= last_in;
         snap_ff     <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

   `AXHS_ASSERT(a_start_init, clock, reset, ctrl.load && item.action == ACTION_START |=> step_ff == STEP_INIT && !snap_ff, "start item did not rearm the sequencer")
   `AXHS_ASSERT(a_end_idle, clock, reset, ctrl.load |=> !(dec_ff.done || dec_ff.err != ERR_NONE) || step_ff == STEP_IDLE, "completion or error left the sequencer active")
   `AXHS_ASSERT(a_plan_snap, clock, reset, ctrl.load |=> !dec_ff.issue || (snap_ff && last_ff == $past(item.override_percent)), "plan issued without override snapshot")

endmodule

// File: sv/axis_homing_sequencer.sv
// ----------------------------------------------------------------------------
// Axis homing sequencer
// Homing method sequencer for one motion axis with override-scaled plans.
// ----------------------------------------------------------------------------
// Usage: each servo tick the controller sends one item on the req_ channel,
// either a start (action low, carrying the target home position) or a tick
// (action high, carrying the sampled switch and index bytes, positions,
// planner status and speed override). Every item produces exactly one item
// on the rsp_ channel: a plan command, a completion with the home offset, an
// error code, or all zeros. Registers are set through the APB-style port,
// which always answers with pready high and reads back the stored value.
// The pipeline takes one item every cycle while the receiver keeps up; the
// three-stage override scaler (product, split reciprocal multiply, final
// add) sets the depth. A result waiting on a stalled receiver holds the
// output register; items keep entering until the internal stages are
// full, then req_ready drops. Reset clears all stage valid bits, the
// registers and the homing state (step init, override snapshot invalid,
// last override 100).
// ----------------------------------------------------------------------------
`include "axis_homing_sequencer_defines.svh"

module axis_homing_sequencer
   import axhs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic signed [POS_W-1:0] req_home_position,
   input  logic [7:0]              req_switch_byte,
   input  logic [7:0]              req_index_byte,
   input  logic signed [POS_W-1:0] req_actual_position,
   input  logic signed [POS_W-1:0] req_planner_position,
   input  logic                    req_planner_done,
   input  logic [PCT_W-1:0]        req_override_percent,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_plan_issue,
   output logic [1:0]              rsp_plan_kind,
   output logic signed [31:0]      rsp_plan_velocity,
   output logic [MAG_W-1:0]        rsp_plan_accel,
   output logic [MAG_W-1:0]        rsp_plan_jerk,
   output logic                    rsp_hold_position,
   output logic signed [POS_W-1:0] rsp_home_offset,
   output logic                    rsp_done_res,
   output logic [1:0]              rsp_error,

   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   localparam logic [QUOT_W-1:0] POS_LIMIT = QUOT_W'(32'h7FFF_FFFF);
   localparam logic [QUOT_W-1:0] NEG_LIMIT = QUOT_W'(32'h8000_0000);
   localparam logic [POS_W-1:0]  OFS_MAX   = {1'b0, {(POS_W - 1){1'b1}}};
   localparam logic [POS_W-1:0]  OFS_MIN   = {1'b1, {(POS_W - 1){1'b0}}};

   cfg_type      cfg;
   item_type     item_ff;
   item_type     item_in;
   dec_type      dec_s1;
   dec_type      dec_s2_ff;
   dec_type      dec_s3_ff;
   seq_ctrl_type seq_ctrl;
   stage_en_type stage_en;

   // Stage valid bits; stage 4 is the output register.
   logic v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic en0, en1, en2, en3, en4;

   logic [QUOT_W-1:0] q_search;
   logic [QUOT_W-1:0] q_return;
   logic [QUOT_W-1:0] q_accel;
   logic [QUOT_W-1:0] q_jerk;

   logic                    rsp_plan_issue_ff, rsp_plan_issue_in;
   logic [1:0]              rsp_plan_kind_ff, rsp_plan_kind_in;
   logic signed [31:0]      rsp_plan_velocity_ff, rsp_plan_velocity_in;
   logic [MAG_W-1:0]        rsp_plan_accel_ff, rsp_plan_accel_in;
   logic [MAG_W-1:0]        rsp_plan_jerk_ff, rsp_plan_jerk_in;
   logic                    rsp_hold_position_ff, rsp_hold_position_in;
   logic signed [POS_W-1:0] rsp_home_offset_ff, rsp_home_offset_in;
   logic                    rsp_done_res_ff, rsp_done_res_in;
   logic [1:0]              rsp_error_ff, rsp_error_in;

   logic [QUOT_W-1:0] speed;
   logic [31:0]       vmag;

   // Each stage moves forward when it is empty or the stage after it moves.
   assign en4 = !rsp_valid_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;
   assign req_ready = en0;

   assign seq_ctrl.adv  = en1;
   assign seq_ctrl.load = en1 && v0_ff;
   assign stage_en.s1   = en1;
   assign stage_en.s2   = en2;
   assign stage_en.s3   = en3;

   assign item_in.action           = req_action;
   assign item_in.home_position    = req_home_position;
   assign item_in.switch_byte      = req_switch_byte;
   assign item_in.index_byte       = req_index_byte;
   assign item_in.actual_position  = req_actual_position;
   assign item_in.planner_position = req_planner_position;
   assign item_in.planner_done     = req_planner_done;
   assign item_in.override_percent = req_override_percent;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= req_valid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) rsp_valid_ff <= v3_ff;
      end
   end

   // Input register: the item is captured as it is accepted.
   always_ff @(posedge clock) begin
      if (en0) begin
         item_ff <= item_in;
      end
   end

   axhs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   axhs_seq u_seq (
      .clock (clock),
      .reset (reset),
      .ctrl  (seq_ctrl),
      .cfg   (cfg),
      .item  (item_ff),
      .dec   (dec_s1)
   );

   // All four magnitudes are scaled for every item; the output stage picks.
   axhs_scale u_scale_search (
      .clock (clock),
      .en    (stage_en),
      .mag   (cfg.search_speed),
      .pct   (item_ff.override_percent),
      .quot  (q_search)
   );

   axhs_scale u_scale_return (
      .clock (clock),
      .en    (stage_en),
      .mag   (cfg.return_speed),
      .pct   (item_ff.override_percent),
      .quot  (q_return)
   );

   axhs_scale u_scale_accel (
      .clock (clock),
      .en    (stage_en),
      .mag   (cfg.accel_limit),
      .pct   (item_ff.override_percent),
      .quot  (q_accel)
   );

   axhs_scale u_scale_jerk (
      .clock (clock),
      .en    (stage_en),
      .mag   (cfg.jerk_limit),
      .pct   (item_ff.override_percent),
      .quot  (q_jerk)
   );

   // The decision travels beside the scaler so both arrive together.
   always_ff @(posedge clock) begin
      if (en2) dec_s2_ff <= dec_s1;
      if (en3) dec_s3_ff <= dec_s2_ff;
   end

   // Output stage: select the speed, apply sign and saturation, and clamp
   // the home offset to the 48-bit signed range.
   always_comb begin
      speed = (dec_s3_ff.kind == KIND_SEARCH) ? q_search : q_return;
      if (dec_s3_ff.neg) begin
         vmag = (speed > NEG_LIMIT) ? NEG_LIMIT[31:0] : speed[31:0];
      end else begin
         vmag = (speed > POS_LIMIT) ? POS_LIMIT[31:0] : speed[31:0];
      end

      rsp_plan_issue_in    = dec_s3_ff.issue;
      rsp_plan_kind_in     = 2'd0;
      rsp_plan_velocity_in = '0;
      rsp_plan_accel_in    = '0;
      rsp_plan_jerk_in     = '0;
      if (dec_s3_ff.issue) begin
         rsp_plan_kind_in     = dec_s3_ff.kind;
         rsp_plan_velocity_in = dec_s3_ff.neg ? (32'd0 - vmag) : vmag;
         rsp_plan_accel_in    = (q_accel > POS_LIMIT) ? POS_LIMIT[MAG_W-1:0]
                                                      : q_accel[MAG_W-1:0];
         rsp_plan_jerk_in     = (q_jerk > POS_LIMIT) ? POS_LIMIT[MAG_W-1:0]
                                                     : q_jerk[MAG_W-1:0];
      end

      rsp_home_offset_in = '0;
      if (dec_s3_ff.done) begin
         if (dec_s3_ff.diff[POS_W] != dec_s3_ff.diff[POS_W-1]) begin
            rsp_home_offset_in = dec_s3_ff.diff[POS_W] ? OFS_MIN : OFS_MAX;
         end else begin
            rsp_home_offset_in = dec_s3_ff.diff[POS_W-1:0];
         end
      end

      rsp_hold_position_in = dec_s3_ff.hold;
      rsp_done_res_in      = dec_s3_ff.done;
      rsp_error_in         = dec_s3_ff.err;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rsp_plan_issue_ff    <= rsp_plan_issue_in;
         rsp_plan_kind_ff     <= rsp_plan_kind_in;
         rsp_plan_velocity_ff <= rsp_plan_velocity_in;
         rsp_plan_accel_ff    <= rsp_plan_accel_in;
         rsp_plan_jerk_ff     <= rsp_plan_jerk_in;
         rsp_hold_position_ff <= rsp_hold_position_in;
         rsp_home_offset_ff   <= rsp_home_offset_in;
         rsp_done_res_ff      <= rsp_done_res_in;
         rsp_error_ff         <= rsp_error_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_plan_issue    = rsp_plan_issue_ff;
   assign rsp_plan_kind     = rsp_plan_kind_ff;
   assign rsp_plan_velocity = rsp_plan_velocity_ff;
   assign rsp_plan_accel    = rsp_plan_accel_ff;
   assign rsp_plan_jerk     = rsp_plan_jerk_ff;
   assign rsp_hold_position = rsp_hold_position_ff;
   assign rsp_home_offset   = rsp_home_offset_ff;
   assign rsp_done_res      = rsp_done_res_ff;
   assign rsp_error         = rsp_error_ff;
   assign pready            = 1'b1;

   `AXHS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid_ff, "result valid right after reset")
   `AXHS_ASSERT(a_empty_ready, clock, reset, !rsp_valid_ff |-> req_ready, "input stalled with an empty output register")
   `AXHS_ASSERT(a_hold_done, clock, reset, rsp_valid_ff && rsp_hold_position_ff |-> rsp_done_res_ff, "index hold without completion")
   `AXHS_ASSERT(a_done_good, clock, reset, rsp_valid_ff && rsp_done_res_ff |-> rsp_error_ff == ERR_NONE, "completion reported with an error code")

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Axis homing sequencer testbench
// Drives start and tick items through the homing sequencer under several
// register settings and random handshake stalls, predicts every result with
// an independent model of the homing state machine and override scaling,
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import axhs_pkg::*;

   // Pipeline depth from the accepting edge to rsp_valid.
   localparam int LATENCY = 4;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_SETS = 12;
   localparam int ITEMS_PER_SET = 96;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [MAG_W-1:0] MAG_MAX = '1;
   localparam logic [PROD_W-1:0] POS_SPEED_CAP = PROD_W'(64'h7FFF_FFFF);
   localparam logic [PROD_W-1:0] NEG_SPEED_CAP = PROD_W'(64'h8000_0000);

   // One result item as the sequencer reports it.
   typedef struct packed {
      logic                    plan_issue;
      kind_type                plan_kind;
      logic signed [31:0]      plan_velocity;
      logic [MAG_W-1:0]        plan_accel;
      logic [MAG_W-1:0]        plan_jerk;
      logic                    hold_position;
      logic signed [POS_W-1:0] home_offset;
      logic                    done_res;
      err_type                 fault;
   } homing_result_type;

   // ------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input has a known value from
   // time zero on.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_action = 1'b1;
   logic signed [POS_W-1:0] req_home_position = '0;
   logic [7:0]              req_switch_byte = '0;
   logic [7:0]              req_index_byte = '0;
   logic signed [POS_W-1:0] req_actual_position = '0;
   logic signed [POS_W-1:0] req_planner_position = '0;
   logic                    req_planner_done = 1'b0;
   logic [PCT_W-1:0]        req_override_percent = PCT_UNITY;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_plan_issue;
   logic [1:0]              rsp_plan_kind;
   logic signed [31:0]      rsp_plan_velocity;
   logic [MAG_W-1:0]        rsp_plan_accel;
   logic [MAG_W-1:0]        rsp_plan_jerk;
   logic                    rsp_hold_position;
   logic signed [POS_W-1:0] rsp_home_offset;
   logic                    rsp_done_res;
   logic [1:0]              rsp_error;

   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [ADDR_W-1:0]       paddr = '0;
   logic [DATA_W-1:0]       pwdata = '0;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   always #5 clock = ~clock;

   axis_homing_sequencer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_home_position    (req_home_position),
      .req_switch_byte      (req_switch_byte),
      .req_index_byte       (req_index_byte),
      .req_actual_position  (req_actual_position),
      .req_planner_position (req_planner_position),
      .req_planner_done     (req_planner_done),
      .req_override_percent (req_override_percent),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_plan_issue       (rsp_plan_issue),
      .rsp_plan_kind        (rsp_plan_kind),
      .rsp_plan_velocity    (rsp_plan_velocity),
      .rsp_plan_accel       (rsp_plan_accel),
      .rsp_plan_jerk        (rsp_plan_jerk),
      .rsp_hold_position    (rsp_hold_position),
      .rsp_home_offset      (rsp_home_offset),
      .rsp_done_res         (rsp_done_res),
      .rsp_error            (rsp_error),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // ------------------------------------------------------------------------
   // Shared testbench state.
   // ------------------------------------------------------------------------
   item_type          pending_items[$];     // items waiting for the driver
   homing_result_type expected_results[$];  // predictions, oldest first

   // Register shadow, updated when a write completes on the bus.
   cfg_type cfg = '0;

   // Predicted homing state, mirrored from the sequencer's reset values.
   step_type                home_step = STEP_INIT;
   logic signed [POS_W-1:0] home_target = '0;
   logic signed [POS_W-1:0] home_captured = '0;
   logic [PCT_W-1:0]        snap_pct = PCT_UNITY;
   logic                    snap_valid = 1'b0;

   // Percentage of cycles in which each side holds back.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int mismatches = 0;
   int starts_sent = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int plans_seen = 0;
   int dones_seen = 0;
   int faults_seen = 0;
   int holds_seen = 0;
   int settings_used = 0;

   // ------------------------------------------------------------------------
   // Prediction.
   // ------------------------------------------------------------------------

   // Homing method bits {polarity, search negative, return negative,
   // stop on index, index only after switch}. Direct modes get the neutral
   // pattern, since a tick in a moving state may still see them when the
   // mode register changes between runs.
   function automatic method_type method_of(input logic [3:0] mode);
      case (mode)
         4'd1:    return method_type'(5'b11011);
         4'd2:    return method_type'(5'b01011);
         4'd3:    return method_type'(5'b10111);
         4'd4:    return method_type'(5'b00111);
         4'd5:    return method_type'(5'b11001);
         4'd6:    return method_type'(5'b01001);
         4'd7:    return method_type'(5'b10101);
         4'd8:    return method_type'(5'b00101);
         4'd9:    return method_type'(5'b11110);
         4'd10:   return method_type'(5'b01110);
         4'd11:   return method_type'(5'b10010);
         4'd12:   return method_type'(5'b00010);
         4'd13:   return method_type'(5'b11011);
         4'd14:   return method_type'(5'b10111);
         default: return method_type'(5'b00011);
      endcase
   endfunction

   // floor(magnitude * percent / 100) with the full product width.
   function automatic logic [PROD_W-1:0] apply_override(input logic [MAG_W-1:0] mag,
                                                        input logic [PCT_W-1:0] pct);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(mag) * PROD_W'(pct);
      return prod / PROD_W'(100);
   endfunction

   // Fills in a plan command and records the override it was made with.
   function automatic void load_plan(inout homing_result_type r, input kind_type kind,
                                     input logic neg, input logic [PCT_W-1:0] pct);
      logic [PROD_W-1:0] speed;
      logic [PROD_W-1:0] acc;
      logic [PROD_W-1:0] jrk;
      speed = apply_override(kind == KIND_SEARCH ? cfg.search_speed : cfg.return_speed,
                             pct);
      acc = apply_override(cfg.accel_limit, pct);
      jrk = apply_override(cfg.jerk_limit, pct);
      r.plan_issue = 1'b1;
      r.plan_kind = kind;
      // A negative speed may reach -2^31, a positive one stops at 2^31 - 1.
      if (neg) begin
         if (speed > NEG_SPEED_CAP) speed = NEG_SPEED_CAP;
         r.plan_velocity = ~speed[31:0] + 32'd1;
      end else begin
         if (speed > POS_SPEED_CAP) speed = POS_SPEED_CAP;
         r.plan_velocity = speed[31:0];
      end
      r.plan_accel = (acc > POS_SPEED_CAP) ? MAG_MAX : acc[MAG_W-1:0];
      r.plan_jerk = (jrk > POS_SPEED_CAP) ? MAG_MAX : jrk[MAG_W-1:0];
      snap_pct = pct;
      snap_valid = 1'b1;
   endfunction

   // Reports the home offset, saturated to 48 bits, and parks the sequence.
   function automatic void close_homing(inout homing_result_type r);
      logic [POS_W:0] diff;
      diff = {home_target[POS_W-1], home_target} - {home_captured[POS_W-1], home_captured};
      if (diff[POS_W] != diff[POS_W-1]) r.home_offset = diff[POS_W] ? POS_MIN : POS_MAX;
      else r.home_offset = diff[POS_W-1:0];
      r.done_res = 1'b1;
      home_step = STEP_IDLE;
   endfunction

   // Advances the predicted sequencer by one accepted item.
   function automatic homing_result_type advance_homing(input item_type it);
      homing_result_type r;
      method_type        m;
      logic [3:0]        mode;
      logic              at_switch;
      logic              at_index;
      logic              pct_moved;
      r = '0;
      if (it.action == ACTION_START) begin
         home_target = it.home_position;
         home_captured = '0;
         home_step = STEP_INIT;
         snap_pct = PCT_UNITY;
         snap_valid = 1'b0;
         return r;
      end
      mode = cfg.homing_mode;
      m = method_of(mode);
      at_switch = it.switch_byte[cfg.switch_bit] == m.pol;
      at_index = it.index_byte[cfg.index_bit];
      pct_moved = !snap_valid || it.override_percent != snap_pct;
      case (home_step)
         STEP_INIT: begin
            if (mode == MODE_DIRECT || mode == MODE_DIRECT_ALT) begin
               home_captured = it.actual_position;
               close_homing(r);
            end else if (cfg.search_speed == '0 || cfg.return_speed == '0) begin
               r.fault = ERR_SPEED;
               home_step = STEP_IDLE;
            end else if (cfg.accel_limit == '0) begin
               r.fault = ERR_ACCEL;
               home_step = STEP_IDLE;
            end else begin
               load_plan(r, KIND_SEARCH, m.sneg, it.override_percent);
               home_step = STEP_SEARCH;
            end
         end
         STEP_SEARCH: begin
            if (at_switch) begin
               // Methods that look for the index without leaving the switch
               // go straight to the index search.
               if (m.soi && !m.aft) begin
                  load_plan(r, KIND_INDEX, m.rneg, it.override_percent);
                  home_step = STEP_INDEX;
               end else begin
                  load_plan(r, KIND_RETURN, m.rneg, it.override_percent);
                  home_step = STEP_RETURN;
               end
            end else if (pct_moved) begin
               load_plan(r, KIND_SEARCH, m.sneg, it.override_percent);
            end
         end
         STEP_RETURN: begin
            if (!at_switch) begin
               if (m.soi) begin
                  load_plan(r, KIND_INDEX, m.rneg, it.override_percent);
                  home_step = STEP_INDEX;
               end else begin
                  home_captured = it.actual_position;
                  load_plan(r, KIND_APPROACH, m.rneg, it.override_percent);
                  home_step = STEP_APPROACH;
               end
            end else if (pct_moved) begin
               load_plan(r, KIND_RETURN, m.rneg, it.override_percent);
            end
         end
         STEP_APPROACH: begin
            if (pct_moved) load_plan(r, KIND_APPROACH, m.rneg, it.override_percent);
            if (it.planner_done) close_homing(r);
         end
         STEP_INDEX: begin
            if (at_index) begin
               home_captured = it.planner_position;
               r.hold_position = 1'b1;
               close_homing(r);
            end else if (it.planner_done || pct_moved) begin
               load_plan(r, KIND_INDEX, m.rneg, it.override_percent);
            end
         end
         default: begin
            home_step = STEP_IDLE;
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Checking helpers.
   // ------------------------------------------------------------------------
   function automatic string show_result(input homing_result_type r);
      return $sformatf("plan=%0b kind=%0d vel=%0d acc=%0d jerk=%0d hold=%0b ofs=%0d done=%0b err=%0d",
                       r.plan_issue, r.plan_kind, r.plan_velocity, r.plan_accel,
                       r.plan_jerk, r.hold_position, r.home_offset, r.done_res, r.fault);
   endfunction

   function automatic void report_fail(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
   endfunction

   function automatic void check_result(input homing_result_type want,
                                        input homing_result_type seen);
      string bad;
      bad = "";
      if (seen.plan_issue !== want.plan_issue) bad = {bad, " plan_issue"};
      if (seen.plan_kind !== want.plan_kind) bad = {bad, " plan_kind"};
      if (seen.plan_velocity !== want.plan_velocity) bad = {bad, " plan_velocity"};
      if (seen.plan_accel !== want.plan_accel) bad = {bad, " plan_accel"};
      if (seen.plan_jerk !== want.plan_jerk) bad = {bad, " plan_jerk"};
      if (seen.hold_position !== want.hold_position) bad = {bad, " hold_position"};
      if (seen.home_offset !== want.home_offset) bad = {bad, " home_offset"};
      if (seen.done_res !== want.done_res) bad = {bad, " done_res"};
      if (seen.fault !== want.fault) bad = {bad, " error"};
      if (bad != "") begin
         report_fail($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                               results_seen, bad, show_result(want), show_result(seen)));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: presents queued items and hands each accepted one to the
   // predictor. The payload only changes once the previous item is taken,
   // and req_valid gets at most one assignment per edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : item_driver
      item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            next_item.action = req_action;
            next_item.home_position = req_home_position;
            next_item.switch_byte = req_switch_byte;
            next_item.index_byte = req_index_byte;
            next_item.actual_position = req_actual_position;
            next_item.planner_position = req_planner_position;
            next_item.planner_done = req_planner_done;
            next_item.override_percent = req_override_percent;
            expected_results.push_back(advance_homing(next_item));
            if (next_item.action == ACTION_START) starts_sent++;
            else ticks_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               req_action <= next_item.action;
               req_home_position <= next_item.home_position;
               req_switch_byte <= next_item.switch_byte;
               req_index_byte <= next_item.index_byte;
               req_actual_position <= next_item.actual_position;
               req_planner_position <= next_item.planner_position;
               req_planner_done <= next_item.planner_done;
               req_override_percent <= next_item.override_percent;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: takes results, compares them with the oldest prediction and
   // stalls the result channel at random.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      homing_result_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.plan_issue = rsp_plan_issue;
            seen.plan_kind = kind_type'(rsp_plan_kind);
            seen.plan_velocity = rsp_plan_velocity;
            seen.plan_accel = rsp_plan_accel;
            seen.plan_jerk = rsp_plan_jerk;
            seen.hold_position = rsp_hold_position;
            seen.home_offset = rsp_home_offset;
            seen.done_res = rsp_done_res;
            seen.fault = err_type'(rsp_error);
            results_seen++;
            if (rsp_plan_issue === 1'b1) plans_seen++;
            if (rsp_done_res === 1'b1) dones_seen++;
            if (rsp_error != ERR_NONE) faults_seen++;
            if (rsp_hold_position === 1'b1) holds_seen++;
            if (expected_results.size() == 0) begin
               report_fail($sformatf("result %0d arrived with nothing expected: %s",
                                     results_seen, show_result(seen)));
            end else begin
               check_result(expected_results.pop_front(), seen);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Random 48-bit position, now and then at either end of the range so that
   // the offset saturation gets exercised.
   function automatic logic signed [POS_W-1:0] pick_position();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       return POS_MAX;
         1:       return POS_MIN;
         default: return w[POS_W-1:0];
      endcase
   endfunction

   // Override mostly at unity, sometimes at its ends or anywhere.
   function automatic logic [PCT_W-1:0] pick_pct();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return PCT_W'($urandom_range(255));
         default: return PCT_UNITY;
      endcase
   endfunction

   function automatic logic [MAG_W-1:0] pick_magnitude(input int zero_odds);
      if ($urandom_range(zero_odds - 1) == 0) return '0;
      case ($urandom_range(5))
         0:       return MAG_MAX;
         1, 2:    return MAG_W'($urandom_range(1, 1 << 20));
         default: return MAG_W'($urandom);
      endcase
   endfunction

   function automatic item_type start_item(input logic signed [POS_W-1:0] target);
      item_type it;
      it.action = ACTION_START;
      it.home_position = target;
      it.switch_byte = 8'($urandom);
      it.index_byte = 8'($urandom);
      it.actual_position = pick_position();
      it.planner_position = pick_position();
      it.planner_done = 1'($urandom);
      it.override_percent = 8'($urandom);
      return it;
   endfunction

   // A tick whose switch reads active or not under the current method, with
   // the unused byte bits and the ignored fields random.
   function automatic item_type tick_item(input logic at_switch, input logic at_index,
                                          input logic planner_done,
                                          input logic [PCT_W-1:0] pct);
      item_type   it;
      method_type m;
      m = method_of(cfg.homing_mode);
      it.action = ~ACTION_START;
      it.home_position = pick_position();
      it.switch_byte = 8'($urandom);
      it.switch_byte[cfg.switch_bit] = at_switch ? m.pol : !m.pol;
      it.index_byte = 8'($urandom);
      it.index_byte[cfg.index_bit] = at_index;
      it.actual_position = pick_position();
      it.planner_position = pick_position();
      it.planner_done = planner_done;
      it.override_percent = pct;
      return it;
   endfunction

   // Holds the sender back until the block has answered every item.
   task automatic wait_quiet();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // One register write: the setup phase, then the access phase, whose closing
   // edge stores the value since pready is tied high.
   task automatic csr_write(input reg_type sel, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (sel)
         REG_HOMING_MODE:  cfg.homing_mode = value[3:0];
         REG_SWITCH_BIT:   cfg.switch_bit = value[2:0];
         REG_INDEX_BIT:    cfg.index_bit = value[2:0];
         REG_SEARCH_SPEED: cfg.search_speed = value[MAG_W-1:0];
         REG_RETURN_SPEED: cfg.return_speed = value[MAG_W-1:0];
         REG_ACCEL_LIMIT:  cfg.accel_limit = value[MAG_W-1:0];
         REG_JERK_LIMIT:   cfg.jerk_limit = value[MAG_W-1:0];
         default: ;
      endcase
   endtask

   // Drains the block, then rewrites every register.
   task automatic apply_settings(input cfg_type c);
      wait_quiet();
      csr_write(REG_HOMING_MODE, DATA_W'(c.homing_mode));
      csr_write(REG_SWITCH_BIT, DATA_W'(c.switch_bit));
      csr_write(REG_INDEX_BIT, DATA_W'(c.index_bit));
      csr_write(REG_SEARCH_SPEED, DATA_W'(c.search_speed));
      csr_write(REG_RETURN_SPEED, DATA_W'(c.return_speed));
      csr_write(REG_ACCEL_LIMIT, DATA_W'(c.accel_limit));
      csr_write(REG_JERK_LIMIT, DATA_W'(c.jerk_limit));
      settings_used++;
   endtask

   function automatic cfg_type settings(input logic [3:0] mode, input int sbit, input int ibit,
                                        input logic [MAG_W-1:0] search,
                                        input logic [MAG_W-1:0] ret,
                                        input logic [MAG_W-1:0] acc,
                                        input logic [MAG_W-1:0] jrk);
      cfg_type c;
      c.homing_mode = mode;
      c.switch_bit = 3'(sbit);
      c.index_bit = 3'(ibit);
      c.search_speed = search;
      c.return_speed = ret;
      c.accel_limit = acc;
      c.jerk_limit = jrk;
      return c;
   endfunction

   // A start followed by ticks whose switch level, index pulse, planner
   // status and override move the way a real axis would, so that most runs
   // walk through search, return and index or approach to completion.
   function automatic int queue_homing_run();
      item_type   it;
      int         n;
      logic       level;
      logic [7:0] pct;
      n = $urandom_range(3, 24);
      level = 1'($urandom);
      pct = pick_pct();
      pending_items.push_back(start_item(pick_position()));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(3) == 0) level = !level;
         if ($urandom_range(9) == 0) pct = pick_pct();
         it = tick_item(level, $urandom_range(6) == 0, $urandom_range(4) == 0, pct);
         pending_items.push_back(it);
      end
      return n + 1;
   endfunction

   // Unshaped items: random action and every field random.
   function automatic int queue_noise();
      item_type it;
      int       n;
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
         it = start_item(pick_position());
         it.action = 1'($urandom);
         pending_items.push_back(it);
      end
      return n;
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence: reset, the directed cases, the random sets in three
   // handshake phases, then the drain and the verdict.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      item_type it;
      cfg_type  c;
      int       set_items;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 9;
      recv_idle_pct = 59;

      // Direct homing at the extremes: the offset saturates both ways, and a
      // tick after completion answers all zeros. Zero jerk is allowed here.
      apply_settings(settings(MODE_DIRECT, 7, 7, MAG_MAX, MAG_MAX, MAG_MAX, '0));
      pending_items.push_back(start_item(POS_MAX));
      it = tick_item(1'b0, 1'b0, 1'b0, PCT_UNITY);
      it.actual_position = POS_MIN;
      pending_items.push_back(it);
      pending_items.push_back(tick_item(1'b1, 1'b1, 1'b1, '1));
      pending_items.push_back(start_item(POS_MIN));
      it = tick_item(1'b0, 1'b0, 1'b0, PCT_UNITY);
      it.actual_position = POS_MAX;
      pending_items.push_back(it);

      // Mode fifteen behaves like direct homing.
      apply_settings(settings(MODE_DIRECT_ALT, 0, 0, 1, 1, 1, 1));
      pending_items.push_back(start_item('0));
      pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0, PCT_UNITY));

      // Method 1 at full speed and full override: the negative search speed
      // clips to -2^31, the positive return speed to 2^31 - 1. An unchanged
      // override issues nothing, a changed one reissues; then index search,
      // a reissue on planner done, and capture on the index pulse.
      apply_settings(settings(4'd1, 3, 5, MAG_MAX, MAG_MAX, MAG_MAX, MAG_MAX));
      pending_items.push_back(start_item(pick_position()));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, '1));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, '1));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, '0));
      pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0, PCT_UNITY));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, PCT_UNITY));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b1, PCT_UNITY));
      pending_items.push_back(tick_item(1'b0, 1'b1, 1'b0, PCT_UNITY));

      // Method 9 searches the index while still on the switch.
      apply_settings(settings(4'd9, 1, 6, 32'h0001_0000, 32'h0000_8000, 32'h0004_0000,
                              32'h0010_0000));
      pending_items.push_back(start_item(pick_position()));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, 8'd50));
      pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0, 8'd50));

      // Method 5 stops at the switch edge: capture on leaving the switch,
      // then completion on planner done.
      apply_settings(settings(4'd5, 2, 4, 32'h0002_0000, 32'h0001_0000, 32'h0008_0000,
                              '0));
      pending_items.push_back(start_item(pick_position()));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, 8'd150));
      pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0, 8'd150));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, 8'd150));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b1, 8'd150));

      // Zero return speed is a speed error; zero acceleration comes next.
      apply_settings(settings(4'd2, 0, 0, MAG_MAX, '0, MAG_MAX, MAG_MAX));
      pending_items.push_back(start_item(pick_position()));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, PCT_UNITY));
      apply_settings(settings(4'd14, 4, 3, 1, 1, '0, 1));
      pending_items.push_back(start_item(pick_position()));
      pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, PCT_UNITY));

      // Random sets. Each set drains the block, picks new register values,
      // and mixes mostly well-formed homing runs with some noise. The first
      // third stalls the receiver hard, the second the sender, the last
      // neither.
      for (int s = 0; s < RANDOM_SETS; s++) begin
         case (s / (RANDOM_SETS / 3))
            0:       begin send_idle_pct = 9;  recv_idle_pct = 59; end
            1:       begin send_idle_pct = 59; recv_idle_pct = 9;  end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         c.homing_mode = ($urandom_range(7) == 0) ? 4'($urandom_range(1) * 15)
                                                  : 4'($urandom_range(1, 14));
         c.switch_bit = 3'($urandom);
         c.index_bit = 3'($urandom);
         c.search_speed = pick_magnitude(12);
         c.return_speed = pick_magnitude(12);
         c.accel_limit = pick_magnitude(12);
         c.jerk_limit = pick_magnitude(6);
         apply_settings(c);
         set_items = 0;
         while (set_items < ITEMS_PER_SET) begin
            if ($urandom_range(9) == 0) set_items += queue_noise();
            else set_items += queue_homing_run();
         end
      end

      // Let the last results come out, then leave room for a stray one.
      wait_quiet();
      repeat (4 * LATENCY) @(posedge clock);

      $display("Covered %0d starts and %0d ticks under %0d register settings.",
               starts_sent, ticks_sent, settings_used);
      $display("Checked %0d results: %0d plans, %0d completions, %0d index captures, %0d errors.",
               results_seen, plans_seen, dones_seen, holds_seen, faults_seen);
      if (mismatches == 0) begin
         $display("axis_homing_sequencer verification clean");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("axis_homing_sequencer verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, with both sides stalling.
   initial begin : watchdog
      #2_000_000;
      $display("Timed out with %0d results still expected.", expected_results.size());
      $display("axis_homing_sequencer verification failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/axhs_pkg.sv
sv/axhs_csr.sv
sv/axhs_scale.sv
sv/axhs_seq.sv
sv/axis_homing_sequencer.sv
test/testbench.sv
